// ----- sv/ecsm_pkg.sv -----
package ecsm_pkg;
  localparam int FIELD_BITS = 16;
  localparam int SCALAR_BITS = 16;
  localparam logic [FIELD_BITS-1:0] PRIME_RESET = FIELD_BITS'(65521);
  localparam logic [FIELD_BITS-1:0] A_RESET = '0;
  localparam logic [0:0] REG_PRIME = 1'b0;
  localparam logic [0:0] REG_A = 1'b1;

  typedef logic [FIELD_BITS-1:0] fe_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RED_START, OP_MUL, OP_ADD, OP_SUB, OP_INV, OP_MOV, OP_SHIFT_K
  } op_t;

  // register file slots
  typedef enum logic [3:0] {
    R_BX, R_BY, R_AX, R_AY, R_A, R_T0, R_T1, R_T2, R_LAM, R_RX, R_K3, R_ZERO
  } reg_t;

  typedef struct packed {
    op_t  op;
    reg_t dst;
    reg_t src_a;
    reg_t src_b;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic inv_fail;
    logic k_zero;
    logic k_lsb;
    logic k_one;
    logic eq_zero;
    logic acc_inf;
    logic base_inf;
    logic x_eq;
    logic y_eq;
  } stat_t;
endpackage

// ----- sv/ecsm_datapath.sv -----
module ecsm_datapath (
  input  logic               clk,
  input  logic               rst,
  input  ecsm_pkg::cmd_t     cmd,
  input  logic               cmd_valid,
  input  ecsm_pkg::fe_t      prime,
  input  ecsm_pkg::fe_t      coef_a,
  input  ecsm_pkg::fe_t      in_x,
  input  ecsm_pkg::fe_t      in_y,
  input  logic [ecsm_pkg::SCALAR_BITS-1:0] in_k,
  output ecsm_pkg::stat_t    stat,
  output ecsm_pkg::fe_t      acc_x,
  output ecsm_pkg::fe_t      acc_y
);
  localparam int FB = ecsm_pkg::FIELD_BITS;
  localparam int RB = 2 * FB + 1;
  localparam int IB = FB + 2;

  ecsm_pkg::fe_t rf [12];
  logic [ecsm_pkg::SCALAR_BITS-1:0] kreg;

  // shared multicycle unit: modular reduce (restoring) and extended Euclid
  typedef enum logic [2:0] {U_IDLE, U_RED, U_DIV, U_UPD, U_FIN} ustate_t;
  ustate_t ust;
  logic [RB-1:0] rem;
  logic [FB-1:0] quo;
  logic [FB:0] dvs;
  logic [$clog2(RB+1)-1:0] cnt;
  ecsm_pkg::reg_t udst;
  logic is_inv;
  logic [FB:0] r0, r1;
  logic signed [IB-1:0] t0, t1;
  logic signed [IB-1:0] qt;
  logic busy_u, ufail;

  ecsm_pkg::fe_t a_v, b_v;
  assign a_v = rf[cmd.src_a];
  assign b_v = rf[cmd.src_b];

  logic [RB-1:0] cand;
  logic [2*FB-1:0] prod;
  logic [RB-1:0] trial;
  assign trial = (RB)'(dvs) << (cnt - 1'b1);
  assign prod = a_v * b_v;

  logic [FB+1:0] addv, subv;
  assign addv = {2'b0, a_v} + {2'b0, b_v};
  assign subv = {2'b0, a_v} + {2'b0, prime} - {2'b0, b_v};

  logic signed [IB+FB:0] qmul;
  assign qmul = $signed({1'b0, quo}) * t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ust <= U_IDLE;
      ufail <= 1'b0;
    end else begin
      rf[ecsm_pkg::R_ZERO] <= '0;
      unique case (ust)
        U_IDLE: if (cmd_valid) begin
          udst <= cmd.dst;
          unique case (cmd.op)
            ecsm_pkg::OP_LOAD: begin
              rf[ecsm_pkg::R_BX] <= in_x; rf[ecsm_pkg::R_BY] <= in_y;
              rf[ecsm_pkg::R_A] <= coef_a; rf[ecsm_pkg::R_AX] <= '0;
              rf[ecsm_pkg::R_AY] <= '0; rf[ecsm_pkg::R_K3] <= FB'(3);
              kreg <= in_k; ufail <= 1'b0;
            end
            ecsm_pkg::OP_RED_START: begin
              rem <= (RB)'(a_v); dvs <= {1'b0, prime};
              cnt <= ($clog2(RB+1))'(FB); quo <= '0; is_inv <= 1'b0; ust <= U_RED;
            end
            ecsm_pkg::OP_MUL: begin
              rem <= (RB)'(prod); dvs <= {1'b0, prime};
              cnt <= ($clog2(RB+1))'(FB + 1); quo <= '0; is_inv <= 1'b0; ust <= U_RED;
            end
            ecsm_pkg::OP_ADD: rf[cmd.dst] <= (addv >= {2'b0, prime}) ?
                FB'(addv - {2'b0, prime}) : FB'(addv);
            ecsm_pkg::OP_SUB: rf[cmd.dst] <= (subv >= {2'b0, prime}) ?
                FB'(subv - {2'b0, prime}) : FB'(subv);
            ecsm_pkg::OP_MOV: rf[cmd.dst] <= a_v;
            ecsm_pkg::OP_SHIFT_K: kreg <= kreg >> 1;
            ecsm_pkg::OP_INV: begin
              r0 <= {1'b0, prime}; r1 <= {1'b0, a_v};
              t0 <= '0; t1 <= IB'(1); is_inv <= 1'b1;
              ust <= (a_v == '0) ? U_FIN : U_DIV;
            end
            default: ;
          endcase
        end
        U_RED: begin
          // one quotient bit per cycle
          if (rem >= trial) begin
            rem <= rem - trial;
            quo <= {quo[FB-2:0], 1'b1};
          end else begin
            quo <= {quo[FB-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == 1) ust <= is_inv ? U_UPD : U_FIN;
        end
        U_DIV: begin
          rem <= (RB)'(r0); dvs <= r1; quo <= '0;
          cnt <= ($clog2(RB+1))'(FB + 1); ust <= U_RED;
        end
        U_UPD: begin
          r0 <= r1; r1 <= (FB+1)'(rem);
          t0 <= t1; t1 <= t0 - IB'(qmul);
          ust <= (rem == '0) ? U_FIN : U_DIV;
        end
        U_FIN: begin
          ust <= U_IDLE;
          if (is_inv) begin
            if (r0 != (FB+1)'(1)) ufail <= 1'b1;
            else rf[udst] <= t0[IB-1] ? FB'(t0 + $signed({2'b0, prime})) : FB'(t0);
          end else begin
            rf[udst] <= FB'(rem);
          end
        end
        default: ust <= U_IDLE;
      endcase
    end
  end

  assign busy_u = (ust != U_IDLE);
  assign cand = '0;
  assign acc_x = rf[ecsm_pkg::R_AX];
  assign acc_y = rf[ecsm_pkg::R_AY];
  assign stat.done = !busy_u && !cmd_valid;
  assign stat.inv_fail = ufail;
  assign stat.k_zero = (kreg == '0) && (cand == '0);
  assign stat.k_lsb = kreg[0];
  assign stat.k_one = (kreg >> 1) == '0;
  assign stat.eq_zero = (a_v == '0);
  assign stat.acc_inf = (rf[ecsm_pkg::R_AX] == '0) && (rf[ecsm_pkg::R_AY] == '0);
  assign stat.base_inf = (rf[ecsm_pkg::R_BX] == '0) && (rf[ecsm_pkg::R_BY] == '0);
  assign stat.x_eq = (a_v == b_v);
  assign stat.y_eq = (rf[ecsm_pkg::R_AY] == rf[ecsm_pkg::R_BY]);
endmodule

// ----- sv/ecsm_ctrl.sv -----
module ecsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            small_p,
  input  ecsm_pkg::stat_t stat,
  output ecsm_pkg::cmd_t  cmd,
  output logic            cmd_valid,
  output logic            busy,
  output logic            finish,
  output logic            fail
);
  // microprogram: most steps issue one command then wait for done; others only branch on status
  typedef enum logic [5:0] {
    S_IDLE, S_RX, S_RY, S_RA, S_LOOP, S_ADD_CHK, S_ADD_XEQ, S_ADD_CHKY,
    S_A_SX, S_A_INV, S_A_SY, S_A_LAM, S_A_L2, S_A_X1, S_A_X2, S_A_D, S_A_Y1,
    S_A_Y2, S_A_WX, S_A_WY, S_SHIFT, S_DBL_CHK, S_D_Y2, S_D_ZC, S_D_INV, S_D_XX,
    S_D_X3, S_D_NA, S_D_LAM, S_D_L2, S_D_X1, S_D_X2, S_D_D, S_D_Y1, S_D_Y2B,
    S_D_WX, S_D_WY, S_A_CPB, S_A_CPBY, S_A_ZERO, S_A_ZY, S_D_ZERO, S_D_ZY, S_DONE,
    S_ERR, S_WAIT
  } state_t;
  state_t st, ret;
  logic dbl;

  task automatic issue(input ecsm_pkg::op_t o, input ecsm_pkg::reg_t d,
                       input ecsm_pkg::reg_t a, input ecsm_pkg::reg_t b);
    cmd <= '{op: o, dst: d, src_a: a, src_b: b};
    cmd_valid <= 1'b1;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; cmd_valid <= 1'b0; finish <= 1'b0; fail <= 1'b0;
      cmd <= '{op: ecsm_pkg::OP_NONE, dst: ecsm_pkg::R_ZERO,
               src_a: ecsm_pkg::R_ZERO, src_b: ecsm_pkg::R_ZERO};
      ret <= S_IDLE; dbl <= 1'b0;
    end else begin
      cmd_valid <= 1'b0; finish <= 1'b0;
      unique case (st)
        // busy is already low during the result strobe, so start is ignored while finish is high
        S_IDLE: if (start && !finish) begin
          if (small_p) begin fail <= 1'b1; finish <= 1'b1; end
          else begin
            issue(ecsm_pkg::OP_LOAD, ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO);
            st <= S_WAIT; ret <= S_RX;
          end
        end
        S_WAIT: if (stat.done) st <= ret;
        S_RX: begin issue(ecsm_pkg::OP_RED_START, ecsm_pkg::R_BX, ecsm_pkg::R_BX, ecsm_pkg::R_ZERO); st <= S_WAIT; ret <= S_RY; end
        S_RY: begin issue(ecsm_pkg::OP_RED_START, ecsm_pkg::R_BY, ecsm_pkg::R_BY, ecsm_pkg::R_ZERO); st <= S_WAIT; ret <= S_RA; end
        S_RA: begin issue(ecsm_pkg::OP_RED_START, ecsm_pkg::R_A, ecsm_pkg::R_A, ecsm_pkg::R_ZERO); st <= S_WAIT; ret <= S_LOOP; end
        S_LOOP: begin
          if (stat.inv_fail) st <= S_ERR;
          else if (stat.k_zero) st <= S_DONE;
          else if (stat.k_lsb) st <= S_ADD_CHK;
          else st <= S_SHIFT;
        end
        // acc = acc + base; src_a/src_b compare x
        S_ADD_CHK: begin
          if (stat.acc_inf) st <= S_A_CPB;
          else if (stat.base_inf) st <= S_SHIFT;
          else begin
            issue(ecsm_pkg::OP_MOV, ecsm_pkg::R_ZERO, ecsm_pkg::R_AX, ecsm_pkg::R_BX);
            st <= S_ADD_XEQ;
          end
        end
        S_ADD_XEQ: begin
          if (!stat.x_eq) st <= S_A_SX;
          else begin
            issue(ecsm_pkg::OP_ADD, ecsm_pkg::R_T0, ecsm_pkg::R_AY, ecsm_pkg::R_BY);
            st <= S_WAIT; ret <= S_ADD_CHKY;
          end
        end
        S_ADD_CHKY: begin
          cmd.src_a <= ecsm_pkg::R_T0;
          st <= S_A_ZERO;
        end
        S_A_ZERO: begin
          if (stat.eq_zero) begin
            issue(ecsm_pkg::OP_MOV, ecsm_pkg::R_AX, ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO);
            st <= S_WAIT; ret <= S_A_ZY;
          end else if (stat.y_eq) begin
            // same point: double acc in place via doubling path on acc
            dbl <= 1'b0; st <= S_D_Y2;
          end else st <= S_A_SX;
        end
        S_A_ZY: begin issue(ecsm_pkg::OP_MOV, ecsm_pkg::R_AY, ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO); st <= S_WAIT; ret <= S_SHIFT; end
        S_A_CPB: begin issue(ecsm_pkg::OP_MOV, ecsm_pkg::R_AX, ecsm_pkg::R_BX, ecsm_pkg::R_ZERO); st <= S_WAIT; ret <= S_A_CPBY; end
        S_A_CPBY: begin issue(ecsm_pkg::OP_MOV, ecsm_pkg::R_AY, ecsm_pkg::R_BY, ecsm_pkg::R_ZERO); st <= S_WAIT; ret <= S_SHIFT; end
        S_A_SX: begin issue(ecsm_pkg::OP_SUB, ecsm_pkg::R_T0, ecsm_pkg::R_BX, ecsm_pkg::R_AX); st <= S_WAIT; ret <= S_A_INV; end
        S_A_INV: begin issue(ecsm_pkg::OP_INV, ecsm_pkg::R_T1, ecsm_pkg::R_T0, ecsm_pkg::R_ZERO); st <= S_WAIT; ret <= S_A_SY; end
        S_A_SY: begin
          if (stat.inv_fail) st <= S_ERR;
          else begin issue(ecsm_pkg::OP_SUB, ecsm_pkg::R_T0, ecsm_pkg::R_BY, ecsm_pkg::R_AY); st <= S_WAIT; ret <= S_A_LAM; end
        end
        S_A_LAM: begin issue(ecsm_pkg::OP_MUL, ecsm_pkg::R_LAM, ecsm_pkg::R_T0, ecsm_pkg::R_T1); st <= S_WAIT; ret <= S_A_L2; end
        S_A_L2: begin issue(ecsm_pkg::OP_MUL, ecsm_pkg::R_T2, ecsm_pkg::R_LAM, ecsm_pkg::R_LAM); st <= S_WAIT; ret <= S_A_X1; end
        S_A_X1: begin issue(ecsm_pkg::OP_SUB, ecsm_pkg::R_T2, ecsm_pkg::R_T2, ecsm_pkg::R_AX); st <= S_WAIT; ret <= S_A_X2; end
        S_A_X2: begin issue(ecsm_pkg::OP_SUB, ecsm_pkg::R_RX, ecsm_pkg::R_T2, ecsm_pkg::R_BX); st <= S_WAIT; ret <= S_A_D; end
        S_A_D: begin issue(ecsm_pkg::OP_SUB, ecsm_pkg::R_T0, ecsm_pkg::R_AX, ecsm_pkg::R_RX); st <= S_WAIT; ret <= S_A_Y1; end
        S_A_Y1: begin issue(ecsm_pkg::OP_MUL, ecsm_pkg::R_T0, ecsm_pkg::R_LAM, ecsm_pkg::R_T0); st <= S_WAIT; ret <= S_A_Y2; end
        S_A_Y2: begin issue(ecsm_pkg::OP_SUB, ecsm_pkg::R_AY, ecsm_pkg::R_T0, ecsm_pkg::R_AY); st <= S_WAIT; ret <= S_A_WX; end
        S_A_WX: begin issue(ecsm_pkg::OP_MOV, ecsm_pkg::R_AX, ecsm_pkg::R_RX, ecsm_pkg::R_ZERO); st <= S_WAIT; ret <= S_A_WY; end
        S_A_WY: st <= S_SHIFT;
        S_SHIFT: begin
          if (stat.inv_fail) st <= S_ERR;
          else if (stat.k_one) begin
            issue(ecsm_pkg::OP_SHIFT_K, ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO);
            st <= S_WAIT; ret <= S_LOOP;
          end else begin
            issue(ecsm_pkg::OP_SHIFT_K, ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO);
            st <= S_WAIT; ret <= S_DBL_CHK;
          end
        end
        // base = 2*base (dbl=1) or acc = 2*acc (dbl=0)
        S_DBL_CHK: begin
          dbl <= 1'b1;
          if (stat.base_inf) st <= S_LOOP;
          else st <= S_D_Y2;
        end
        S_D_Y2: begin
          issue(ecsm_pkg::OP_ADD, ecsm_pkg::R_T0, dbl ? ecsm_pkg::R_BY : ecsm_pkg::R_AY,
                dbl ? ecsm_pkg::R_BY : ecsm_pkg::R_AY);
          st <= S_WAIT; ret <= S_D_ZC;
        end
        S_D_ZC: begin cmd.src_a <= ecsm_pkg::R_T0; st <= S_D_ZERO; end
        S_D_ZERO: begin
          if (stat.eq_zero) begin
            issue(ecsm_pkg::OP_MOV, dbl ? ecsm_pkg::R_BX : ecsm_pkg::R_AX,
                  ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO);
            st <= S_WAIT; ret <= S_D_ZY;
          end else st <= S_D_INV;
        end
        S_D_ZY: begin
          issue(ecsm_pkg::OP_MOV, dbl ? ecsm_pkg::R_BY : ecsm_pkg::R_AY,
                ecsm_pkg::R_ZERO, ecsm_pkg::R_ZERO);
          st <= S_WAIT; ret <= dbl ? S_LOOP : S_SHIFT;
        end
        S_D_INV: begin issue(ecsm_pkg::OP_INV, ecsm_pkg::R_T1, ecsm_pkg::R_T0, ecsm_pkg::R_ZERO); st <= S_WAIT; ret <= S_D_XX; end
        S_D_XX: begin
          if (stat.inv_fail) st <= S_ERR;
          else begin
            issue(ecsm_pkg::OP_MUL, ecsm_pkg::R_T0, dbl ? ecsm_pkg::R_BX : ecsm_pkg::R_AX,
                  dbl ? ecsm_pkg::R_BX : ecsm_pkg::R_AX);
            st <= S_WAIT; ret <= S_D_X3;
          end
        end
        S_D_X3: begin issue(ecsm_pkg::OP_MUL, ecsm_pkg::R_T0, ecsm_pkg::R_K3, ecsm_pkg::R_T0); st <= S_WAIT; ret <= S_D_NA; end
        S_D_NA: begin issue(ecsm_pkg::OP_ADD, ecsm_pkg::R_T0, ecsm_pkg::R_T0, ecsm_pkg::R_A); st <= S_WAIT; ret <= S_D_LAM; end
        S_D_LAM: begin issue(ecsm_pkg::OP_MUL, ecsm_pkg::R_LAM, ecsm_pkg::R_T0, ecsm_pkg::R_T1); st <= S_WAIT; ret <= S_D_L2; end
        S_D_L2: begin issue(ecsm_pkg::OP_MUL, ecsm_pkg::R_T2, ecsm_pkg::R_LAM, ecsm_pkg::R_LAM); st <= S_WAIT; ret <= S_D_X1; end
        S_D_X1: begin issue(ecsm_pkg::OP_SUB, ecsm_pkg::R_T2, ecsm_pkg::R_T2, dbl ? ecsm_pkg::R_BX : ecsm_pkg::R_AX); st <= S_WAIT; ret <= S_D_X2; end
        S_D_X2: begin issue(ecsm_pkg::OP_SUB, ecsm_pkg::R_RX, ecsm_pkg::R_T2, dbl ? ecsm_pkg::R_BX : ecsm_pkg::R_AX); st <= S_WAIT; ret <= S_D_D; end
        S_D_D: begin issue(ecsm_pkg::OP_SUB, ecsm_pkg::R_T0, dbl ? ecsm_pkg::R_BX : ecsm_pkg::R_AX, ecsm_pkg::R_RX); st <= S_WAIT; ret <= S_D_Y1; end
        S_D_Y1: begin issue(ecsm_pkg::OP_MUL, ecsm_pkg::R_T0, ecsm_pkg::R_LAM, ecsm_pkg::R_T0); st <= S_WAIT; ret <= S_D_Y2B; end
        S_D_Y2B: begin
          issue(ecsm_pkg::OP_SUB, dbl ? ecsm_pkg::R_BY : ecsm_pkg::R_AY, ecsm_pkg::R_T0,
                dbl ? ecsm_pkg::R_BY : ecsm_pkg::R_AY);
          st <= S_WAIT; ret <= S_D_WX;
        end
        S_D_WX: begin
          issue(ecsm_pkg::OP_MOV, dbl ? ecsm_pkg::R_BX : ecsm_pkg::R_AX, ecsm_pkg::R_RX,
                ecsm_pkg::R_ZERO);
          st <= S_WAIT; ret <= S_D_WY;
        end
        S_D_WY: st <= dbl ? S_LOOP : S_SHIFT;
        S_DONE: begin fail <= 1'b0; finish <= 1'b1; st <= S_IDLE; end
        S_ERR: begin fail <= 1'b1; finish <= 1'b1; st <= S_IDLE; end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign busy = (st != S_IDLE);
endmodule

// ----- sv/ec_scalar_multiply_affine.sv -----
// Computes k*P on y^2 = x^3 + a*x + b over GF(p) by right-to-left double-and-add.
// One request at a time: point_x, point_y and scalar are captured at the edge where
// start is high and busy is low; busy then stays high up to and including the single
// result strobe (done), which lasts one cycle and cannot be held off. Latency is set by
// the shared bit-serial reduce/divide unit, which performs each modular multiply and
// each division round of the Euclidean inverse, while adds and subtracts bypass it.
// A worst-case request runs 2*SCALAR_BITS-1 point operations; small scalars finish
// sooner. no_inverse flags a missing inverse or p < 3.
module ec_scalar_multiply_affine (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] point_x,
  input  logic [15:0] point_y,
  input  logic [15:0] scalar,
  output logic        done,
  output logic [15:0] result_x,
  output logic [15:0] result_y,
  output logic        no_inverse,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  ecsm_pkg::fe_t prime, coef_a;
  ecsm_pkg::cmd_t cmd;
  ecsm_pkg::stat_t stat;
  logic cmd_valid, finish, fail, ctrl_busy;
  ecsm_pkg::fe_t ax, ay;
  ecsm_pkg::fe_t req_x, req_y;
  logic [ecsm_pkg::SCALAR_BITS-1:0] req_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= ecsm_pkg::PRIME_RESET;
      coef_a <= ecsm_pkg::A_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ecsm_pkg::REG_PRIME: prime <= cfg_data;
        ecsm_pkg::REG_A:     coef_a <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold the request; the datapath loads it in the next cycle
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_x <= point_x;
      req_y <= point_y;
      req_k <= scalar;
    end
  end

  ecsm_ctrl u_ctrl (
    .clk, .rst, .start, .small_p(prime < 16'd3), .stat,
    .cmd, .cmd_valid, .busy(ctrl_busy), .finish, .fail
  );

  ecsm_datapath u_dp (
    .clk, .rst, .cmd, .cmd_valid, .prime, .coef_a,
    .in_x(req_x), .in_y(req_y), .in_k(req_k),
    .stat, .acc_x(ax), .acc_y(ay)
  );

  assign busy = ctrl_busy || finish;
  assign done = finish;
  assign no_inverse = fail;
  assign result_x = fail ? '0 : ax;
  assign result_y = fail ? '0 : ay;
endmodule

// ----- sv/ecsm_checker.sv -----
module ecsm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic no_inverse,
  input logic [15:0] result_x,
  input logic [15:0] result_y
);
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && no_inverse |-> result_x == 16'd0 && result_y == 16'd0)
    else $error("error result not zero");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without busy");
  a_idle_no_done: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !done) else $error("done out of nowhere");
endmodule

bind ec_scalar_multiply_affine ecsm_checker u_ecsm_checker (
  .clk, .rst, .start, .busy, .done, .no_inverse, .result_x, .result_y
);
